### rtl/wxs_pkg.sv
// ----------------------------------------------------------------------------
// wxs_pkg
// Shared types and constants for the exact signed-rank significance core.
// ----------------------------------------------------------------------------
package wxs_pkg;

	localparam int MAX_PAIRS_DEF       = 63;
	localparam int SUM_TABLE_DEPTH_DEF = 2048;

	localparam int N_W      = 6;
	localparam int HALVES_W = 12;
	localparam int WC_W     = 12;
	localparam int MAXSUM_W = 11;
	localparam int COUNT_W  = 64;
	localparam int P_W      = 34;
	localparam int SH_W     = 6;

	// p = count * 2^(P_REF - n)
	localparam int P_REF = 33;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CLEAR,
		ST_PASS,
		ST_RD,
		ST_UPD,
		ST_FIN_RD,
		ST_FIN_ADD,
		ST_SCALE1,
		ST_SCALE2,
		ST_DONE
	} wxs_state_t;

	typedef enum logic {
		ALU_ADD_SHL,
		ALU_SHR
	} alu_op_t;

	typedef struct packed {
		alu_op_t           op;
		logic [SH_W-1:0]   sh;
	} alu_req_t;

endpackage

### rtl/wxs_ram.sv
// ----------------------------------------------------------------------------
// wxs_ram
// Path count table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module wxs_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### rtl/wxs_alu.sv
// ----------------------------------------------------------------------------
// wxs_alu
// Shared shift-add unit: y = a + (b << sh), or y = b >> sh.
// ----------------------------------------------------------------------------
module wxs_alu
	import wxs_pkg::*;
(
	input  alu_req_t             req,
	input  logic [COUNT_W-1:0]   a,
	input  logic [COUNT_W-1:0]   b,
	output logic [COUNT_W-1:0]   y
);

	always_comb begin
		case (req.op)
			ALU_ADD_SHL: y = a + (b << req.sh);
			ALU_SHR:     y = b >> req.sh;
			default:     y = '0;
		endcase
	end

endmodule

### rtl/wilcoxon_exact_significance_core.sv
// ----------------------------------------------------------------------------
// wilcoxon_exact_significance_core
// Exact signed-rank tail count and two-tailed p by a table walk over n..2.
// ----------------------------------------------------------------------------
//  channel | signals                                        | dir
//  in      | in_valid, in_ready, sample_size, rank_sum_halves | sink
//  out     | out_valid, out_ready, subset_count, p_value,   | source
//          | range_error                                    |
//
//  Trivial cases skip the table walk.
//  Table walk: table entries 1..Wc are cleared, then each pass has one setup
//  state and table steps of one read of both table ports and one shared
//  shift-add, over passes n..2 of min(Wc, m(m+1)/2) steps.
//  in_ready is high only while idle; a finished result waits in the output
//  register while the next item is taken. Reset clears control only.
// ----------------------------------------------------------------------------
module wilcoxon_exact_significance_core
	import wxs_pkg::*;
#(
	parameter int MAX_PAIRS       = MAX_PAIRS_DEF,
	parameter int SUM_TABLE_DEPTH = SUM_TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [N_W-1:0]      sample_size,
	input  logic [HALVES_W-1:0] rank_sum_halves,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COUNT_W-1:0]  subset_count,
	output logic [P_W-1:0]      p_value,
	output logic                range_error
);

	localparam int AW = $clog2(SUM_TABLE_DEPTH);

	wxs_state_t state_q, state_d;
	logic       out_valid_q;

	logic [N_W-1:0]      n_q, m_q;
	logic [WC_W-1:0]     wc_q;
	logic [MAXSUM_W-1:0] maxsum_q, ms_q;
	logic [AW-1:0]       limit_q, i_q, j_q;
	logic [COUNT_W-1:0]  tail_q, count_q;
	logic [P_W-1:0]      p_q;
	logic                err_q;
	logic [COUNT_W-1:0]  cnt_out_q;
	logic [P_W-1:0]      p_out_q;
	logic                err_out_q;

	logic                in_xfer, out_xfer, load_out;
	logic [11:0]         prod;
	logic [HALVES_W-1:0] h_refl;
	logic [HALVES_W:0]   h_p1;

	logic               we;
	logic [AW-1:0]      waddr, raddr_a, raddr_b;
	logic [COUNT_W-1:0] wdata, rd_a, rd_b;
	alu_req_t           areq;
	logic [COUNT_W-1:0] alu_a, alu_b, alu_y;

	logic i_le_m, i_last, j_last, n_small;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid_q && out_ready;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	assign subset_count = cnt_out_q;
	assign p_value      = p_out_q;
	assign range_error  = err_out_q;

	assign prod   = 12'(sample_size) * (12'(sample_size) + 12'd1);
	assign h_refl = (rank_sum_halves < {1'b0, prod[11:2], 1'b0}) ?
	                (prod - rank_sum_halves) : rank_sum_halves;
	assign h_p1   = {1'b0, h_refl} + 13'd1;

	assign i_le_m  = (WC_W'(i_q) <= WC_W'(m_q));
	assign i_last  = (i_q == limit_q);
	assign j_last  = (j_q == wc_q[AW-1:0]);
	assign n_small = (n_q <= N_W'(P_REF));

	wxs_ram #(
		.DEPTH (SUM_TABLE_DEPTH),
		.WIDTH (COUNT_W)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	wxs_alu u_alu (
		.req (areq),
		.a   (alu_a),
		.b   (alu_b),
		.y   (alu_y)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (n_q > N_W'(MAX_PAIRS)) state_d = ST_DONE;
				else if (n_q == '0 || wc_q == '0 || wc_q > WC_W'(maxsum_q) ||
				         n_q == N_W'(1)) state_d = ST_SCALE1;
				else if (wc_q >= WC_W'(SUM_TABLE_DEPTH)) state_d = ST_DONE;
				else state_d = ST_CLEAR;
			end
			ST_CLEAR: begin
				if (j_last) state_d = ST_PASS;
			end
			ST_PASS:    state_d = ST_RD;
			ST_RD:      state_d = ST_UPD;
			ST_UPD: begin
				if (i_last) state_d = (m_q == N_W'(2)) ? ST_FIN_RD : ST_PASS;
				else state_d = ST_RD;
			end
			ST_FIN_RD:  state_d = ST_FIN_ADD;
			ST_FIN_ADD: state_d = ST_SCALE1;
			ST_SCALE1:  state_d = n_small ? ST_DONE : ST_SCALE2;
			ST_SCALE2:  state_d = ST_DONE;
			ST_DONE: begin
				if (load_out) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// table and shared unit controls
	always_comb begin
		we      = 1'b0;
		waddr   = j_q;
		wdata   = '0;
		raddr_a = i_q;
		raddr_b = i_q - AW'(m_q);
		areq.op = ALU_ADD_SHL;
		areq.sh = '0;
		alu_a   = '0;
		alu_b   = rd_a;
		case (state_q)
			ST_CHECK: begin
				alu_b   = COUNT_W'(1);
				areq.sh = n_q;
			end
			ST_CLEAR: begin
				we    = 1'b1;
				wdata = COUNT_W'(j_last);
			end
			ST_UPD: begin
				if (i_le_m) begin
					alu_a   = tail_q;
					areq.sh = m_q - N_W'(1);
				end else begin
					we    = 1'b1;
					waddr = i_q - AW'(m_q);
					alu_a = rd_b;
					wdata = alu_y;
				end
			end
			ST_FIN_RD: begin
				raddr_a = AW'(1);
			end
			ST_FIN_ADD: begin
				alu_a = tail_q;
			end
			ST_SCALE1: begin
				if (n_small) begin
					alu_b   = count_q;
					areq.sh = SH_W'(P_REF) - n_q;
				end else begin
					alu_a   = count_q;
					alu_b   = COUNT_W'(1);
					areq.sh = n_q - SH_W'(P_REF + 1);
				end
			end
			ST_SCALE2: begin
				areq.op = ALU_SHR;
				alu_b   = tail_q;
				areq.sh = n_q - SH_W'(P_REF);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_xfer) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					n_q      <= sample_size;
					maxsum_q <= prod[11:1];
					wc_q     <= h_p1[HALVES_W:1];
				end
			end
			ST_CHECK: begin
				p_q     <= '0;
				tail_q  <= '0;
				j_q     <= AW'(1);
				m_q     <= n_q;
				ms_q    <= maxsum_q;
				limit_q <= wc_q[AW-1:0];
				if (n_q > N_W'(MAX_PAIRS)) begin
					err_q   <= 1'b1;
					count_q <= '0;
				end else if (n_q == '0) begin
					err_q   <= 1'b0;
					count_q <= '0;
				end else if (wc_q == '0) begin
					err_q   <= 1'b0;
					count_q <= alu_y;
				end else if (wc_q > WC_W'(maxsum_q)) begin
					err_q   <= 1'b0;
					count_q <= '0;
				end else if (n_q == N_W'(1)) begin
					err_q   <= 1'b0;
					count_q <= COUNT_W'(1);
				end else if (wc_q >= WC_W'(SUM_TABLE_DEPTH)) begin
					err_q   <= 1'b1;
					count_q <= '0;
				end else begin
					err_q   <= 1'b0;
					count_q <= '0;
				end
			end
			ST_CLEAR: begin
				j_q <= j_q + AW'(1);
			end
			ST_PASS: begin
				i_q <= AW'(1);
				if (WC_W'(ms_q) < WC_W'(limit_q)) limit_q <= AW'(ms_q);
			end
			ST_UPD: begin
				if (i_le_m) tail_q <= alu_y;
				if (i_last) begin
					m_q  <= m_q - N_W'(1);
					ms_q <= ms_q - MAXSUM_W'(m_q);
				end else begin
					i_q <= i_q + AW'(1);
				end
			end
			ST_FIN_ADD: begin
				count_q <= alu_y;
			end
			ST_SCALE1: begin
				if (n_small) p_q <= alu_y[P_W-1:0];
				else tail_q <= alu_y;
			end
			ST_SCALE2: begin
				p_q <= alu_y[P_W-1:0];
			end
			ST_DONE: begin
				if (load_out) begin
					cnt_out_q <= count_q;
					p_out_q   <= p_q;
					err_out_q <= err_q;
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/wxs_checker.sv
// ----------------------------------------------------------------------------
// wxs_checker
// Port-level checks for the significance core, bound to the top level.
// ----------------------------------------------------------------------------
module wxs_checker
	import wxs_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [COUNT_W-1:0]  subset_count,
	input logic [P_W-1:0]      p_value,
	input logic                range_error
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(subset_count) &&
		$stable(p_value) && $stable(range_error))
		else $error("result changed while stalled");

	// busy right after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready after input transfer");

	// error results carry zeros
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> subset_count == '0 && p_value == '0)
		else $error("nonzero payload on range error");

	// zero count gives zero p
	a_zero_p: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && subset_count == '0 |-> p_value == '0)
		else $error("nonzero p for zero count");

endmodule

bind wilcoxon_exact_significance_core wxs_checker u_wxs_checker (.*);

### test/wilcoxon_exact_significance_core_tb.sv
// ----------------------------------------------------------------------------
// wilcoxon_exact_significance_core_tb
// Drives rank-sum queries through the signed-rank significance core and
// compares each tail count, p value and range flag. A short table of
// directed queries comes first, then random ones. Expected results come from
// a subset-sum count kept in the bench, or from the table for typed rows.
// ----------------------------------------------------------------------------
module wilcoxon_exact_significance_core_tb;
	import wxs_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [P_W-1:0]     p;
		logic               err;
	} tail_result_t;

	typedef struct {
		logic [N_W-1:0]      n;
		logic [HALVES_W-1:0] halves;
		bit                  typed;
		tail_result_t        res;
	} plan_row_t;

	localparam int PLAN_ROWS = 24;
	localparam int RANDOM_ITEMS = 76;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [N_W-1:0]      sample_size;
	logic [HALVES_W-1:0] rank_sum_halves;
	logic                out_valid;
	logic                out_ready;
	logic [COUNT_W-1:0]  subset_count;
	logic [P_W-1:0]      p_value;
	logic                range_error;

	tail_result_t pending_tails [$];
	plan_row_t    plan [PLAN_ROWS];
	int           accepted_items = 0;
	int           error_count = 0;
	int           burst_left = 0;

	wilcoxon_exact_significance_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample_size     (sample_size),
		.rank_sum_halves (rank_sum_halves),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.subset_count    (subset_count),
		.p_value         (p_value),
		.range_error     (range_error)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// subsets of 1..n with sum >= reflected, rounded-up W
	function automatic tail_result_t exact_tail(input logic [N_W-1:0] n,
			input logic [HALVES_W-1:0] halves);
		tail_result_t       r;
		int                 nn;
		int                 hv;
		int                 total;
		int                 wc;
		int                 top;
		logic [COUNT_W-1:0] ways [SUM_TABLE_DEPTH_DEF];
		logic [COUNT_W-1:0] c;
		r = '0;
		nn = int'(n);
		hv = int'(halves);
		if (nn > MAX_PAIRS_DEF) begin
			r.err = 1'b1;
			return r;
		end
		total = nn * (nn + 1) / 2;
		if (hv < 2 * (total / 2))
			hv = 2 * total - hv;
		wc = (hv + 1) / 2;
		if (nn == 0) begin
			c = '0;
		end else if (wc == 0) begin
			c = 64'd1 << nn;
		end else if (wc > total) begin
			c = '0;
		end else begin
			if (wc >= SUM_TABLE_DEPTH_DEF) begin
				r.err = 1'b1;
				return r;
			end
			foreach (ways[i])
				ways[i] = '0;
			ways[0] = 64'd1;
			for (int k = 1; k <= nn; k++) begin
				top = k * (k + 1) / 2;
				for (int s = top; s >= k; s--)
					ways[s] += ways[s - k];
			end
			c = '0;
			for (int s = wc; s <= total; s++)
				c += ways[s];
		end
		r.count = c;
		if (nn <= P_REF)
			r.p = P_W'(c << (P_REF - nn));
		else
			r.p = P_W'((c + (64'd1 << (nn - P_REF - 1))) >> (nn - P_REF));
		return r;
	endfunction

	task automatic offer(input logic [N_W-1:0] n, input logic [HALVES_W-1:0] halves,
			input tail_result_t want);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 15);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		sample_size <= n;
		rank_sum_halves <= halves;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_tails.push_back(want);
		accepted_items++;
		@(negedge clk);
	endtask

	initial begin
		logic [N_W-1:0]      n;
		logic [HALVES_W-1:0] halves;
		int                  pick;
		int                  total;
		int                  big_left;
		in_valid = 1'b0;
		sample_size = '0;
		rank_sum_halves = '0;
		big_left = 3;
		plan = '{
			'{6'd0,  12'd0,    1'b1, '{64'd0, 34'd0, 1'b0}},
			'{6'd0,  12'd4095, 1'b1, '{64'd0, 34'd0, 1'b0}},
			'{6'd1,  12'd0,    1'b1, '{64'd2, 34'h2_0000_0000, 1'b0}},
			'{6'd1,  12'd1,    1'b1, '{64'd1, 34'h1_0000_0000, 1'b0}},
			'{6'd1,  12'd2,    1'b1, '{64'd1, 34'h1_0000_0000, 1'b0}},
			'{6'd1,  12'd3,    1'b1, '{64'd0, 34'd0, 1'b0}},
			'{6'd2,  12'd4095, 1'b1, '{64'd0, 34'd0, 1'b0}},
			'{6'd2,  12'd2,    1'b0, '0},
			'{6'd2,  12'd0,    1'b0, '0},
			'{6'd5,  12'd13,   1'b0, '0},
			'{6'd5,  12'd14,   1'b0, '0},
			'{6'd5,  12'd15,   1'b0, '0},
			'{6'd4,  12'd10,   1'b0, '0},
			'{6'd10, 12'd0,    1'b0, '0},
			'{6'd10, 12'd55,   1'b0, '0},
			'{6'd20, 12'd211,  1'b0, '0},
			'{6'd32, 12'd1365, 1'b0, '0},
			'{6'd33, 12'd561,  1'b0, '0},
			'{6'd34, 12'd595,  1'b0, '0},
			'{6'd40, 12'd0,    1'b0, '0},
			'{6'd63, 12'd4095, 1'b1, '{64'd0, 34'd0, 1'b0}},
			'{6'd63, 12'd4033, 1'b1, '{64'd0, 34'd0, 1'b0}},
			'{6'd63, 12'd4032, 1'b0, '0},
			'{6'd63, 12'd2016, 1'b0, '0}
		};
		@(posedge arst_n);
		@(negedge clk);
		foreach (plan[i])
			offer(plan[i].n, plan[i].halves,
				plan[i].typed ? plan[i].res : exact_tail(plan[i].n, plan[i].halves));
		// mostly small n keeps the walk short; a few large ones
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 4 && big_left > 0) begin
				n = N_W'($urandom_range(25, 63));
				big_left--;
			end else if (pick < 30) begin
				n = N_W'($urandom_range(13, 24));
			end else begin
				n = N_W'($urandom_range(0, 12));
			end
			total = int'(n) * (int'(n) + 1) / 2;
			if ($urandom_range(0, 4) == 0)
				halves = HALVES_W'($urandom_range(0, 4095));
			else
				halves = HALVES_W'($urandom_range(0, 2 * total + 2));
			offer(n, halves, exact_tail(n, halves));
		end
		in_valid <= 1'b0;
		while (pending_tails.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("wilcoxon_exact_significance_core_tb: done, clean");
		else
			$display("wilcoxon_exact_significance_core_tb: done, errors");
		$finish;
	end

	// receiver: one long hold-off early on, then segments of mixed stalling
	initial begin
		bit held;
		int mode;
		int seg_left;
		out_ready = 1'b0;
		held = 1'b0;
		mode = 0;
		seg_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && accepted_items >= 3) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			if (seg_left == 0) begin
				mode = $urandom_range(0, 2);
				seg_left = $urandom_range(20, 200);
			end
			seg_left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= (seg_left % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		tail_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_tails.size() == 0) begin
				$error("result transfer with nothing expected: count %0d p %0h err %0b",
					subset_count, p_value, range_error);
				error_count++;
			end else begin
				want = pending_tails.pop_front();
				if (subset_count !== want.count) begin
					$error("subset_count: expected %0d, got %0d", want.count, subset_count);
					error_count++;
				end
				if (p_value !== want.p) begin
					$error("p_value: expected %0h, got %0h", want.p, p_value);
					error_count++;
				end
				if (range_error !== want.err) begin
					$error("range_error: expected %0b, got %0b", want.err, range_error);
					error_count++;
				end
			end
		end
	end

	initial begin
		#72000000;
		$display("wilcoxon_exact_significance_core_tb: done, errors");
		$finish;
	end

endmodule

### filelist.f
rtl/wxs_pkg.sv
rtl/wxs_ram.sv
rtl/wxs_alu.sv
rtl/wilcoxon_exact_significance_core.sv
rtl/wxs_checker.sv
test/wilcoxon_exact_significance_core_tb.sv
